[design/plane_point_rotator_assert.svh]
// Assertion macros for the rotator; empty when SYNTH is set.
`ifndef PLANE_POINT_ROTATOR_ASSERT_SVH
`define PLANE_POINT_ROTATOR_ASSERT_SVH

`ifndef SYNTH

`define PPR_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

`define PPR_ASSERT_DELAY(name, clk, rst_n, ante, n, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("%m: delayed check failed");

`else

`define PPR_ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define PPR_ASSERT_DELAY(name, clk, rst_n, ante, n, cons)

`endif

`endif

[design/ppr_pkg.sv]
`default_nettype none

package ppr_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int NumStages = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;

  localparam int DegHalf     = 180;
  localparam int AngleScale  = 64;
  localparam int FullTurn    = 2 * DegHalf * AngleScale;
  localparam int HalfTurn    = DegHalf * AngleScale;
  localparam int QuarterTurn = HalfTurn / 2;

  localparam int ZIntMul    = (1 << 23) / 45;
  localparam int ZRemMul    = (1 << 23) % 45;
  localparam int ZRound     = 22;
  localparam int RecipShift = 24;
  localparam int RecipMul   = ((1 << RecipShift) + 44) / 45;

  localparam logic signed [32:0] GainQ32 = 33'sd2608131497;

  localparam int PrepStages = 5;
  localparam int Latency    = PrepStages + NumStages + 1;

  typedef struct packed {
    logic signed [23:0] x_in;
    logic signed [23:0] y_in;
    logic signed [15:0] angle;
  } point_t;

  typedef struct packed {
    logic signed [23:0] x_out;
    logic signed [23:0] y_out;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [41:0] xs;
    logic signed [41:0] ys;
    logic signed [32:0] z;
  } rot_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      5'd30:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[design/ppr_prep.sv]
`default_nettype none

module ppr_prep (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire ppr_pkg::point_t pt_i,
  output logic                valid_o,
  output ppr_pkg::rot_t       rot_o
);

  localparam logic signed [16:0] Full    = 17'(ppr_pkg::FullTurn);
  localparam logic signed [16:0] Half    = 17'(ppr_pkg::HalfTurn);
  localparam logic signed [16:0] Quarter = 17'(ppr_pkg::QuarterTurn);

  logic [4:0] vld_q;

  ppr_pkg::point_t pt0_q;

  logic signed [24:0] x1_d, y1_d, x1_q, y1_q;
  logic               neg1_d, neg1_q;
  logic [12:0]        mag1_d, mag1_q;

  logic signed [41:0] xs2_d, ys2_d, xs2_q, ys2_q, xs3_q, ys3_q;
  logic               neg2_q, neg3_q;
  logic [29:0]        p1_2_d, p1_2_q, p1_3_q;
  logic [17:0]        v2_d, v2_q;
  logic [12:0]        q3_d, q3_q;

  ppr_pkg::rot_t rot_d, rot_q;

  logic signed [16:0] r_a, r_b, r_c, r_d, r_e, r_f, r_m;
  logic               flip;
  logic signed [57:0] px, py, rx, ry;
  logic [36:0]        qprod;
  logic [32:0]        zsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_comb begin
    r_a = {pt0_q.angle[15], pt0_q.angle};
    r_b = (r_a >= Full) ? r_a - Full : r_a;
    r_c = (r_b < 17'sd0) ? r_b + Full : r_b;
    r_d = (r_c < 17'sd0) ? r_c + Full : r_c;
    r_e = (r_d > Half) ? r_d - Full : r_d;
    flip = 1'b0;
    r_f = r_e;
    if (r_e > Quarter) begin
      flip = 1'b1;
      r_f = r_e - Half;
    end else if (r_e < -Quarter) begin
      flip = 1'b1;
      r_f = r_e + Half;
    end
    neg1_d = r_f[16];
    r_m = neg1_d ? -r_f : r_f;
    mag1_d = r_m[12:0];
    x1_d = {pt0_q.x_in[23], pt0_q.x_in};
    y1_d = {pt0_q.y_in[23], pt0_q.y_in};
    if (flip) begin
      x1_d = -x1_d;
      y1_d = -y1_d;
    end
  end

  always_comb begin
    px = x1_q * ppr_pkg::GainQ32;
    py = y1_q * ppr_pkg::GainQ32;
    rx = px + 58'sd32768;
    ry = py + 58'sd32768;
    xs2_d = rx[57:16];
    ys2_d = ry[57:16];
    p1_2_d = 30'(mag1_q) * 30'(ppr_pkg::ZIntMul);
    v2_d = 18'(mag1_q) * 18'(ppr_pkg::ZRemMul) + 18'(ppr_pkg::ZRound);
  end

  always_comb begin
    qprod = 37'(v2_q) * 37'(ppr_pkg::RecipMul);
    q3_d = qprod[ppr_pkg::RecipShift +: 13];
  end

  always_comb begin
    zsum = 33'(p1_3_q) + 33'(q3_q);
    rot_d.xs = xs3_q;
    rot_d.ys = ys3_q;
    rot_d.z  = neg3_q ? -zsum : zsum;
  end

  always_ff @(posedge clk_i) begin
    pt0_q  <= pt_i;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    neg1_q <= neg1_d;
    mag1_q <= mag1_d;
    xs2_q  <= xs2_d;
    ys2_q  <= ys2_d;
    neg2_q <= neg1_q;
    p1_2_q <= p1_2_d;
    v2_q   <= v2_d;
    xs3_q  <= xs2_q;
    ys3_q  <= ys2_q;
    neg3_q <= neg2_q;
    p1_3_q <= p1_2_q;
    q3_q   <= q3_d;
    rot_q  <= rot_d;
  end

  assign valid_o = vld_q[4];
  assign rot_o   = rot_q;

endmodule

`default_nettype wire

[design/ppr_cordic.sv]
`default_nettype none

module ppr_cordic (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ppr_pkg::rot_t rot_i,
  output logic               valid_o,
  output ppr_pkg::rot_t      rot_o
);

  localparam int N = ppr_pkg::NumStages;

  logic [N-1:0]  vld_q;
  ppr_pkg::rot_t stg_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic               vin;
    ppr_pkg::rot_t      cur;
    ppr_pkg::rot_t      nxt;
    logic signed [41:0] xs_c, ys_c, dx, dy;
    logic signed [32:0] z_c, at;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign cur = rot_i;
    end else begin : g_rest
      assign vin = vld_q[i-1];
      assign cur = stg_q[i-1];
    end

    always_comb begin
      xs_c = cur.xs;
      ys_c = cur.ys;
      z_c  = cur.z;
      dx   = ys_c >>> i;
      dy   = xs_c >>> i;
      at   = {1'b0, ppr_pkg::atan_entry(5'(i))};
      if (z_c >= 33'sd0) begin
        nxt.xs = xs_c - dx;
        nxt.ys = ys_c + dy;
        nxt.z  = z_c - at;
      end else begin
        nxt.xs = xs_c + dx;
        nxt.ys = ys_c - dy;
        nxt.z  = z_c + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[i] <= nxt;
    end
  end

  assign valid_o = vld_q[N-1];
  assign rot_o   = stg_q[N-1];

endmodule

`default_nettype wire

[design/plane_point_rotator.sv]
// Channel  Ports                       Handshake
// point    point_i (x_in,y_in,angle)   beat taken when start_i && !busy_o
// result   result_o (x_out,y_out,sat)  beat valid for one cycle while done_o
//
// Accepts one point every cycle; busy_o stays low.
// From accept to the strobe a point passes five preparation stages, one register per
// micro-rotation and one output stage.
// Reset clears the valid bits only; points in flight are dropped.
// The receiver cannot stall, so no beat is ever held back.

`default_nettype none

`include "plane_point_rotator_assert.svh"

module plane_point_rotator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire ppr_pkg::point_t  point_i,
  output logic                  done_o,
  output ppr_pkg::result_t      result_o
);

  localparam logic signed [25:0] OutMax = 26'sd8388607;
  localparam logic signed [25:0] OutMin = -26'sd8388608;

  logic          prep_vld, cor_vld;
  ppr_pkg::rot_t prep_rot, cor_rot;

  logic signed [41:0] xr_full, yr_full;
  logic signed [25:0] xr, yr;
  logic               sat_x, sat_y;

  ppr_pkg::result_t res_d, res_q;
  logic             done_q;

  logic beat_in;
  logic on_rail;

  assign busy_o  = 1'b0;
  assign beat_in = start_i && !busy_o;

  ppr_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (beat_in),
    .pt_i    (point_i),
    .valid_o (prep_vld),
    .rot_o   (prep_rot)
  );

  ppr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_vld),
    .rot_i   (prep_rot),
    .valid_o (cor_vld),
    .rot_o   (cor_rot)
  );

  always_comb begin
    xr_full = cor_rot.xs + 42'sd32768;
    yr_full = cor_rot.ys + 42'sd32768;
    xr = xr_full[41:16];
    yr = yr_full[41:16];
    sat_x = 1'b0;
    sat_y = 1'b0;
    res_d.x_out = xr[23:0];
    res_d.y_out = yr[23:0];
    if (xr > OutMax) begin
      sat_x = 1'b1;
      res_d.x_out = OutMax[23:0];
    end else if (xr < OutMin) begin
      sat_x = 1'b1;
      res_d.x_out = OutMin[23:0];
    end
    if (yr > OutMax) begin
      sat_y = 1'b1;
      res_d.y_out = OutMax[23:0];
    end else if (yr < OutMin) begin
      sat_y = 1'b1;
      res_d.y_out = OutMin[23:0];
    end
    res_d.saturated = sat_x | sat_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  assign on_rail = (result_o.x_out == OutMax[23:0]) || (result_o.x_out == OutMin[23:0]) ||
                   (result_o.y_out == OutMax[23:0]) || (result_o.y_out == OutMin[23:0]);

  `PPR_ASSERT_DELAY(a_beat_latency, clk_i, rst_ni, beat_in, ppr_pkg::Latency, done_o)
  `PPR_ASSERT_IMPLY(a_no_phantom, clk_i, rst_ni, done_o, $past(beat_in, ppr_pkg::Latency))
  `PPR_ASSERT_IMPLY(a_sat_on_rail, clk_i, rst_ni, done_o && result_o.saturated, on_rail)

endmodule

`default_nettype wire

[dv/tb_plane_point_rotator.sv]
module tb_plane_point_rotator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TurnFull    = 23040;
  localparam longint TurnHalf    = 11520;
  localparam longint TurnQuarter = 5760;
  localparam longint GainQ32     = 64'd2608131497;
  localparam int     GuardBits   = 16;
  localparam int     CycleLimit  = 200000;
  localparam int     XMax        = 8388607;
  localparam int     XMin        = -8388608;

  localparam longint ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  class rotation_ledger;
    ppr_pkg::result_t rotated_due[$];
    int               errors;

    function new();
      errors = 0;
    endfunction

    static function longint clamp24(longint v, ref bit clipped);
      if (v > XMax) begin
        clipped = 1'b1;
        return XMax;
      end
      if (v < XMin) begin
        clipped = 1'b1;
        return XMin;
      end
      return v;
    endfunction

    static function ppr_pkg::result_t rotate_point(ppr_pkg::point_t p);
      longint           x, y, r, mag, z, xs, ys, dx, dy;
      bit               clipped;
      ppr_pkg::result_t res;
      x = longint'(p.x_in);
      y = longint'(p.y_in);
      r = longint'(p.angle) % TurnFull;
      clipped = 1'b0;
      if (r < 0) r += TurnFull;
      if (r > TurnHalf) r -= TurnFull;
      if (r > TurnQuarter) begin
        x = -x;
        y = -y;
        r -= TurnHalf;
      end else if (r < -TurnQuarter) begin
        x = -x;
        y = -y;
        r += TurnHalf;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * 64'sd8388608 + 22) / 45;
      if (r < 0) z = -z;
      xs = (x * GainQ32 + (longint'(1) << (31 - GuardBits))) >>> (32 - GuardBits);
      ys = (y * GainQ32 + (longint'(1) << (31 - GuardBits))) >>> (32 - GuardBits);
      for (int i = 0; i < ppr_pkg::ROTATION_STAGES && i < 32; i++) begin
        dx = ys >>> i;
        dy = xs >>> i;
        if (z >= 0) begin
          xs -= dx;
          ys += dy;
          z  -= ATAN_TURNS[i];
        end else begin
          xs += dx;
          ys -= dy;
          z  += ATAN_TURNS[i];
        end
      end
      xs = clamp24((xs + (longint'(1) << (GuardBits - 1))) >>> GuardBits, clipped);
      ys = clamp24((ys + (longint'(1) << (GuardBits - 1))) >>> GuardBits, clipped);
      res.x_out     = 24'(xs);
      res.y_out     = 24'(ys);
      res.saturated = clipped;
      return res;
    endfunction

    function void note_point(ppr_pkg::point_t p);
      rotated_due.insert(rotated_due.size(), rotate_point(p));
    endfunction

    function void check_result(ppr_pkg::result_t got);
      ppr_pkg::result_t want;
      if (rotated_due.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d sat=%0b", $time,
                 got.x_out, got.y_out, got.saturated);
        errors++;
        return;
      end
      want = rotated_due.pop_front();
      if (got.x_out !== want.x_out) begin
        $display("%0t: x_out expected %0d got %0d", $time, want.x_out, got.x_out);
        errors++;
      end
      if (got.y_out !== want.y_out) begin
        $display("%0t: y_out expected %0d got %0d", $time, want.y_out, got.y_out);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction

    function int pending();
      return rotated_due.size();
    endfunction
  endclass

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start_i = 1'b0;
  ppr_pkg::point_t  point_i = '0;
  logic             busy_o;
  logic             done_o;
  ppr_pkg::result_t result_o;

  rotation_ledger ledger = new();
  int             cycles = 0;

  always #2 clk_i = ~clk_i;

  plane_point_rotator u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .point_i  (point_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) ledger.check_result(result_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic ppr_pkg::point_t make_point(int x, int y, int a);
    ppr_pkg::point_t p;
    p.x_in  = 24'(x);
    p.y_in  = 24'(y);
    p.angle = 16'(a);
    return p;
  endfunction

  function automatic logic [23:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 24'($urandom);
      5, 6, 7:       return 24'($signed($urandom_range(0, 131071)) - 65536);
      8:             return $urandom_range(0, 1) ? 24'(XMax) : 24'(XMin);
      default:       return 24'($signed($urandom_range(0, 2097151)) +
                            ($urandom_range(0, 1) ? 6291456 : -8388608));
    endcase
  endfunction

  function automatic logic [15:0] random_angle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom);
      6, 7, 8:          return 16'(($signed($urandom_range(0, 10)) - 5) * 5760 +
                                   $signed($urandom_range(0, 6)) - 3);
      default:          return 16'($signed($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  task automatic send_point(ppr_pkg::point_t p, int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    point_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    ledger.note_point(p);
  endtask

  initial begin
    ppr_pkg::point_t directed[$];
    int              idle_phase[4];
    ppr_pkg::point_t p;

    idle_phase = '{0, 61, 31, 0};
    directed = '{
      make_point(XMax, 0, 0),          make_point(XMin, 0, 0),
      make_point(0, XMax, 5760),       make_point(0, XMin, -5760),
      make_point(XMax, XMax, 2880),    make_point(XMin, XMin, -2880),
      make_point(XMax, XMin, 11520),   make_point(XMin, XMax, -11520),
      make_point(XMin, XMin, 11520),   make_point(4096, 0, 23040),
      make_point(4096, 4096, 32767),   make_point(-4096, 8192, -32768),
      make_point(4096, 0, 5761),       make_point(4096, 0, -5761),
      make_point(4096, -4096, 5759),   make_point(1, 0, 1),
      make_point(-1, -1, -1),          make_point(0, 0, 12345),
      make_point(XMax, XMax, 0),       make_point(4096, 0, 17280),
      make_point(4096, 0, -17280),     make_point(-6000000, 7000000, 1000)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_point(directed[i], 0);

    foreach (idle_phase[ph]) begin
      repeat (420) begin
        p.x_in  = random_coord();
        p.y_in  = random_coord();
        p.angle = random_angle();
        send_point(p, idle_phase[ph]);
      end
    end
    start_i <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (ppr_pkg::Latency + 4) @(posedge clk_i);

    if (ledger.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
